/* rtl/core/pwcm_pkg.sv */
// pwcm_pkg: widths, payload types and shared helpers of the perspective warp mapper
// no dependencies
`default_nettype none
package pwcm_pkg;

	localparam int COORD_BITS     = 12;
	localparam int FRAC_BITS      = 8;
	localparam int COEF_BITS      = 32;
	localparam int COEF_FRAC_BITS = 20;
	localparam int LIMIT_BITS     = 16;
	localparam int CFG_DATA_BITS  = 64;
	localparam int CFG_IDX_BITS   = 3;

	// product of a coefficient with a zero extended coordinate
	localparam int PW = COEF_BITS + COORD_BITS + 1;
	// sum of two products and an offset
	localparam int SW = PW + 2;
	// magnitude after sign normalisation
	localparam int MW = SW - 1;
	// limit times denominator
	localparam int LW = COORD_BITS + MW;
	// quotient bits: integer part and fraction
	localparam int QW = COORD_BITS + FRAC_BITS;
	// partial remainder of the long division
	localparam int RW = MW + 1;

	localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;
	localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

	localparam logic [CFG_IDX_BITS-1:0] REG_XP_GAINS      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_YP_GAINS      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_WP_GAINS      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_XY_OFFSETS    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_W_OFFSET      = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_LIMITS = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_BILINEAR_MODE = 3'd6;

	typedef struct packed {
		logic [COORD_BITS-1:0] out_x;
		logic [COORD_BITS-1:0] out_y;
	} in_word_t;

	typedef struct packed {
		logic                  inside_res;
		logic [COORD_BITS-1:0] src_x;
		logic [COORD_BITS-1:0] src_y;
		logic [FRAC_BITS-1:0]  frac_x;
		logic [FRAC_BITS-1:0]  frac_y;
	} out_word_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] gxx;
		logic signed [COEF_BITS-1:0] gxy;
		logic signed [COEF_BITS-1:0] gyx;
		logic signed [COEF_BITS-1:0] gyy;
		logic signed [COEF_BITS-1:0] gwx;
		logic signed [COEF_BITS-1:0] gwy;
		logic signed [COEF_BITS-1:0] ox;
		logic signed [COEF_BITS-1:0] oy;
		logic signed [COEF_BITS-1:0] ow;
		logic [COORD_BITS-1:0]       limx;
		logic [COORD_BITS-1:0]       limy;
		logic                        bilinear;
	} cfg_t;

	typedef struct packed {
		logic          ok;
		logic [MW-1:0] nx;
		logic [MW-1:0] ny;
		logic [MW-1:0] den;
	} div_in_t;

	typedef struct packed {
		logic          ok;
		logic [QW-1:0] qx;
		logic [QW-1:0] qy;
	} div_out_t;

	// one restoring step: shift in a dividend bit, subtract when it fits
	function automatic logic [RW:0] div_step(input logic [RW-1:0] r,
		input logic [MW-1:0] d, input logic b);
		logic [RW-1:0] t;
		logic [RW:0]   res;
		t = {r[RW-2:0], b};
		if (t >= {1'b0, d}) begin
			res = {1'b1, t - {1'b0, d}};
		end else begin
			res = {1'b0, t};
		end
		return res;
	endfunction

	// limits wider than the coordinate saturate
	function automatic logic [COORD_BITS-1:0] sat_limit(input logic [LIMIT_BITS-1:0] v);
		logic [COORD_BITS-1:0] res;
		if (v > LIMIT_BITS'(COORD_MAX)) begin
			res = COORD_MAX;
		end else begin
			res = v[COORD_BITS-1:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/pwcm_if.sv */
// pwcm_if: handshake channels of the perspective warp mapper
// depends on pwcm_pkg
`default_nettype none
interface pwcm_in_if;
	logic               valid;
	logic               ready;
	pwcm_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pwcm_out_if;
	logic                valid;
	logic                ready;
	pwcm_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pwcm_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [pwcm_pkg::CFG_IDX_BITS-1:0]    index;
	logic [pwcm_pkg::CFG_DATA_BITS-1:0]   wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

/* rtl/core/pwcm_cfg.sv */
// pwcm_cfg: configuration registers of the mapper, decoded into coefficient fields
// depends on pwcm_pkg and pwcm_if
`default_nettype none
module pwcm_cfg (
	input  wire           clk,
	input  wire           arst_n,
	pwcm_cfg_if.sink      cfg,
	output pwcm_pkg::cfg_t cfg_fields
);
	localparam int CB = pwcm_pkg::COEF_BITS;

	logic [pwcm_pkg::CFG_DATA_BITS-1:0] xp_gains_q, yp_gains_q, wp_gains_q, xy_offsets_q;
	logic [CB-1:0]                      w_offset_q;
	logic [CB-1:0]                      source_limits_q;
	logic                               bilinear_mode_q;
	logic                               wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xp_gains_q      <= {{CB{1'b0}}, pwcm_pkg::COEF_ONE};
			yp_gains_q      <= {pwcm_pkg::COEF_ONE, {CB{1'b0}}};
			wp_gains_q      <= '0;
			xy_offsets_q    <= '0;
			w_offset_q      <= pwcm_pkg::COEF_ONE;
			source_limits_q <= '0;
			bilinear_mode_q <= 1'b0;
		end else if (wr) begin
			case (cfg.index)
				pwcm_pkg::REG_XP_GAINS:      xp_gains_q      <= cfg.wdata;
				pwcm_pkg::REG_YP_GAINS:      yp_gains_q      <= cfg.wdata;
				pwcm_pkg::REG_WP_GAINS:      wp_gains_q      <= cfg.wdata;
				pwcm_pkg::REG_XY_OFFSETS:    xy_offsets_q    <= cfg.wdata;
				pwcm_pkg::REG_W_OFFSET:      w_offset_q      <= cfg.wdata[CB-1:0];
				pwcm_pkg::REG_SOURCE_LIMITS: source_limits_q <= cfg.wdata[CB-1:0];
				pwcm_pkg::REG_BILINEAR_MODE: bilinear_mode_q <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg_fields.gxx      = $signed(xp_gains_q[CB-1:0]);
		cfg_fields.gxy      = $signed(xp_gains_q[2*CB-1:CB]);
		cfg_fields.gyx      = $signed(yp_gains_q[CB-1:0]);
		cfg_fields.gyy      = $signed(yp_gains_q[2*CB-1:CB]);
		cfg_fields.gwx      = $signed(wp_gains_q[CB-1:0]);
		cfg_fields.gwy      = $signed(wp_gains_q[2*CB-1:CB]);
		cfg_fields.ox       = $signed(xy_offsets_q[CB-1:0]);
		cfg_fields.oy       = $signed(xy_offsets_q[2*CB-1:CB]);
		cfg_fields.ow       = $signed(w_offset_q);
		cfg_fields.limx     = pwcm_pkg::sat_limit(source_limits_q[pwcm_pkg::LIMIT_BITS-1:0]);
		cfg_fields.limy     = pwcm_pkg::sat_limit(
			source_limits_q[2*pwcm_pkg::LIMIT_BITS-1:pwcm_pkg::LIMIT_BITS]);
		cfg_fields.bilinear = bilinear_mode_q;
	end
endmodule
`default_nettype wire

/* rtl/core/pwcm_map.sv */
// pwcm_map: five stage projection front end: products, sums, sign fix, bound check
// depends on pwcm_pkg
`default_nettype none
module pwcm_map (
	input  wire                  clk,
	input  wire                  arst_n,
	input  pwcm_pkg::cfg_t       cfg_fields,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  pwcm_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  wire                  out_en,
	output pwcm_pkg::div_in_t    out_data
);
	localparam int PW = pwcm_pkg::PW;
	localparam int SW = pwcm_pkg::SW;
	localparam int MW = pwcm_pkg::MW;
	localparam int LW = pwcm_pkg::LW;
	localparam int COORD_BITS_P1 = pwcm_pkg::COORD_BITS + 1;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic signed [PW-1:0] pxx_s1, pxy_s1, pyx_s1, pyy_s1, pwx_s1, pwy_s1;
	logic signed [SW-1:0] xp_s2, yp_s2, wp_s2;
	logic signed [SW-1:0] xn_s3, yn_s3;
	logic [MW-1:0]        wm_s3, wm_s4;
	logic signed [SW-1:0] xn_s4, yn_s4;
	logic [LW-1:0]        bx_s4, by_s4;
	pwcm_pkg::div_in_t    d_s5;

	logic signed [COORD_BITS_P1-1:0] xs, ys;
	logic signed [SW-1:0] wn;

	assign en5 = !v_s5 || out_en;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	assign xs = $signed({1'b0, in_data.out_x});
	assign ys = $signed({1'b0, in_data.out_y});
	assign wn = -wp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			pxx_s1 <= cfg_fields.gxx * xs;
			pxy_s1 <= cfg_fields.gxy * ys;
			pyx_s1 <= cfg_fields.gyx * xs;
			pyy_s1 <= cfg_fields.gyy * ys;
			pwx_s1 <= cfg_fields.gwx * xs;
			pwy_s1 <= cfg_fields.gwy * ys;
		end
		if (en2) begin
			xp_s2 <= SW'(pxx_s1) + SW'(pxy_s1) + SW'(cfg_fields.ox);
			yp_s2 <= SW'(pyx_s1) + SW'(pyy_s1) + SW'(cfg_fields.oy);
			wp_s2 <= SW'(pwx_s1) + SW'(pwy_s1) + SW'(cfg_fields.ow);
		end
		// negative denominator: flip all three
		if (en3) begin
			xn_s3 <= wp_s2[SW-1] ? -xp_s2 : xp_s2;
			yn_s3 <= wp_s2[SW-1] ? -yp_s2 : yp_s2;
			wm_s3 <= wp_s2[SW-1] ? wn[MW-1:0] : wp_s2[MW-1:0];
		end
		if (en4) begin
			xn_s4 <= xn_s3;
			yn_s4 <= yn_s3;
			wm_s4 <= wm_s3;
			bx_s4 <= LW'(cfg_fields.limx) * LW'(wm_s3);
			by_s4 <= LW'(cfg_fields.limy) * LW'(wm_s3);
		end
		if (en5) begin
			d_s5.ok  <= (wm_s4 != '0) && !xn_s4[SW-1] && !yn_s4[SW-1]
				&& (LW'(xn_s4[MW-1:0]) <= bx_s4) && (LW'(yn_s4[MW-1:0]) <= by_s4);
			d_s5.nx  <= xn_s4[MW-1:0];
			d_s5.ny  <= yn_s4[MW-1:0];
			d_s5.den <= wm_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = d_s5;
endmodule
`default_nettype wire

/* rtl/core/pwcm_div.sv */
// pwcm_div: pipelined restoring divider, one quotient bit of x and y per stage
// depends on pwcm_pkg
`default_nettype none
module pwcm_div (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  pwcm_pkg::div_in_t    in_data,
	output logic                 out_valid,
	input  wire                  out_en,
	output pwcm_pkg::div_out_t   out_data
);
	localparam int QW = pwcm_pkg::QW;
	localparam int RW = pwcm_pkg::RW;
	localparam int MW = pwcm_pkg::MW;
	localparam int CB = pwcm_pkg::COORD_BITS;
	localparam int FB = pwcm_pkg::FRAC_BITS;

	// index 0 is the incoming word, 1..QW are the stage registers
	logic          v_s   [QW+1];
	logic          ok_s  [QW+1];
	logic [RW-1:0] rx_s  [QW+1];
	logic [RW-1:0] ry_s  [QW+1];
	logic [QW-1:0] lx_s  [QW+1];
	logic [QW-1:0] ly_s  [QW+1];
	logic [QW-1:0] qx_s  [QW+1];
	logic [QW-1:0] qy_s  [QW+1];
	logic [MW-1:0] d_s   [QW+1];
	logic          en    [QW+2];

	// high dividend bits start the remainder, the rest are shifted in
	assign v_s[0]  = in_valid;
	assign ok_s[0] = in_data.ok;
	assign rx_s[0] = RW'(in_data.nx[MW-1:CB]);
	assign ry_s[0] = RW'(in_data.ny[MW-1:CB]);
	assign lx_s[0] = {in_data.nx[CB-1:0], {FB{1'b0}}};
	assign ly_s[0] = {in_data.ny[CB-1:0], {FB{1'b0}}};
	assign qx_s[0] = '0;
	assign qy_s[0] = '0;
	assign d_s[0]  = in_data.den;
	assign en[QW+1] = out_en;
	assign in_ready = en[1];

	genvar k;
	generate
		for (k = 1; k <= QW; k++) begin : g_stage
			logic [RW:0] sx, sy;
			assign en[k] = !v_s[k] || en[k+1];
			assign sx = pwcm_pkg::div_step(rx_s[k-1], d_s[k-1], lx_s[k-1][QW-1]);
			assign sy = pwcm_pkg::div_step(ry_s[k-1], d_s[k-1], ly_s[k-1][QW-1]);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (en[k]) begin
					ok_s[k] <= ok_s[k-1];
					d_s[k]  <= d_s[k-1];
					rx_s[k] <= sx[RW-1:0];
					ry_s[k] <= sy[RW-1:0];
					lx_s[k] <= {lx_s[k-1][QW-2:0], 1'b0};
					ly_s[k] <= {ly_s[k-1][QW-2:0], 1'b0};
					qx_s[k] <= {qx_s[k-1][QW-2:0], sx[RW]};
					qy_s[k] <= {qy_s[k-1][QW-2:0], sy[RW]};
				end
			end
		end
	endgenerate

	assign out_valid   = v_s[QW];
	assign out_data.ok = ok_s[QW];
	assign out_data.qx = qx_s[QW];
	assign out_data.qy = qy_s[QW];
endmodule
`default_nettype wire

/* rtl/core/perspective_warp_coordinate_mapper.sv */
// perspective_warp_coordinate_mapper: top level, maps output pixels to source coordinates
// depends on pwcm_pkg, pwcm_if, pwcm_cfg, pwcm_map and pwcm_div
//
//  channel   modport  payload
//  pix_in    sink     out_x, out_y
//  pix_out   source   inside_res, src_x, src_y, frac_x, frac_y
//  cfg       sink     index, wdata (always ready)
//
// one word per clock unless the output stalls; 5 projection stages, one divider
// stage per quotient bit (20) and the output register
// arst_n clears every valid bit and loads the register reset values
// a stalled output holds its word; upstream stages keep filling bubbles and
// pix_in.ready drops only when every stage is full
`default_nettype none
module perspective_warp_coordinate_mapper (
	input  wire          clk,
	input  wire          arst_n,
	pwcm_in_if.sink      pix_in,
	pwcm_out_if.source   pix_out,
	pwcm_cfg_if.sink     cfg
);
	localparam int QW = pwcm_pkg::QW;
	localparam int FB = pwcm_pkg::FRAC_BITS;

	pwcm_pkg::cfg_t      cfg_fields;
	pwcm_pkg::div_in_t   map_word;
	pwcm_pkg::div_out_t  div_word;
	pwcm_pkg::out_word_t res_d, res_q;
	logic                map_valid, div_ready, div_valid, out_en, res_valid_q;
	logic [QW-1:0]       rqx, rqy;

	pwcm_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cfg_fields (cfg_fields)
	);

	pwcm_map u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_fields (cfg_fields),
		.in_valid   (pix_in.valid),
		.in_ready   (pix_in.ready),
		.in_data    (pix_in.data),
		.out_valid  (map_valid),
		.out_en     (div_ready),
		.out_data   (map_word)
	);

	pwcm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (map_valid),
		.in_ready  (div_ready),
		.in_data   (map_word),
		.out_valid (div_valid),
		.out_en    (out_en),
		.out_data  (div_word)
	);

	assign out_en = !res_valid_q || pix_out.ready;

	// nearest: add half of the fraction range, then drop the fraction
	assign rqx = div_word.qx + QW'(1 << (FB - 1));
	assign rqy = div_word.qy + QW'(1 << (FB - 1));

	always_comb begin
		res_d = '0;
		if (div_word.ok) begin
			res_d.inside_res = 1'b1;
			if (cfg_fields.bilinear) begin
				res_d.src_x  = div_word.qx[QW-1:FB];
				res_d.src_y  = div_word.qy[QW-1:FB];
				res_d.frac_x = div_word.qx[FB-1:0];
				res_d.frac_y = div_word.qy[FB-1:0];
			end else begin
				res_d.src_x = rqx[QW-1:FB];
				res_d.src_y = rqy[QW-1:FB];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_en) begin
			res_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			res_q <= res_d;
		end
	end

	assign pix_out.valid = res_valid_q;
	assign pix_out.data  = res_q;

	// back pressure reaches the input only through a stalled output
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> (pix_out.valid && !pix_out.ready))
		else $error("input stalled without output back pressure");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && !pix_out.data.inside_res) |->
		(pix_out.data.src_x == '0 && pix_out.data.src_y == '0
		&& pix_out.data.frac_x == '0 && pix_out.data.frac_y == '0))
		else $error("outside word carries a coordinate");

	a_within_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && pix_out.data.inside_res) |->
		(pix_out.data.src_x <= cfg_fields.limx && pix_out.data.src_y <= cfg_fields.limy))
		else $error("inside word beyond source limits");

	a_nearest_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && !cfg_fields.bilinear && $stable(cfg_fields.bilinear)
		&& $past(out_en)) |->
		(pix_out.data.frac_x == '0 && pix_out.data.frac_y == '0))
		else $error("fraction present in nearest mode");
endmodule
`default_nettype wire

/* tb/perspective_warp_coordinate_mapper_test.sv */
// perspective_warp_coordinate_mapper_test: drives pixel words through the warp mapper
// and checks every mapped word against an in-bench projection and division model
// depends on pwcm_pkg, pwcm_if and the top level
`timescale 1ns / 1ps
module perspective_warp_coordinate_mapper_test;
	import pwcm_pkg::*;

	logic clk;
	logic arst_n;
	pwcm_in_if  pix_in ();
	pwcm_out_if pix_out ();
	pwcm_cfg_if cfg ();

	perspective_warp_coordinate_mapper u_dut (
		.clk(clk), .arst_n(arst_n), .pix_in(pix_in), .pix_out(pix_out), .cfg(cfg)
	);

	typedef struct {
		logic [11:0] x;
		logic [11:0] y;
		bit          known;
		out_word_t   want;
	} pix_row_t;

	// shadow copy of the mapping registers
	logic [63:0] sh_xp, sh_yp, sh_wp, sh_off;
	logic [31:0] sh_ow, sh_lim;
	logic        sh_bil;

	out_word_t mapped_q[$];
	int errors = 0;
	int n_words = 0;
	int n_inside = 0;
	longint cycles = 0;
	bit stall_en = 1;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("perspective_warp_coordinate_mapper_test failed");
			$finish;
		end
	end

	function automatic longint sx32(input logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic void split_quot(input longint n, input longint d,
		output logic [11:0] ip, output logic [7:0] fp);
		longint q;
		if (sh_bil) begin
			q = (n <<< FRAC_BITS) / d;
			ip = q[19:8];
			fp = q[7:0];
		end else begin
			q = (2 * n + d) / (2 * d);
			ip = q[11:0];
			fp = '0;
		end
	endfunction

	function automatic out_word_t warp_pixel(input logic [11:0] x, input logic [11:0] y);
		longint xi, yi, xp, yp, wp, lx, ly;
		out_word_t r;
		xi = x;
		yi = y;
		xp = sx32(sh_xp[31:0]) * xi + sx32(sh_xp[63:32]) * yi + sx32(sh_off[31:0]);
		yp = sx32(sh_yp[31:0]) * xi + sx32(sh_yp[63:32]) * yi + sx32(sh_off[63:32]);
		wp = sx32(sh_wp[31:0]) * xi + sx32(sh_wp[63:32]) * yi + sx32(sh_ow);
		lx = sh_lim[15:0];
		ly = sh_lim[31:16];
		if (lx > 4095) lx = 4095;
		if (ly > 4095) ly = 4095;
		if (wp < 0) begin
			wp = -wp; xp = -xp; yp = -yp;
		end
		r = '0;
		if (wp != 0 && xp >= 0 && yp >= 0 && xp <= lx * wp && yp <= ly * wp) begin
			r.inside_res = 1'b1;
			split_quot(xp, wp, r.src_x, r.frac_x);
			split_quot(yp, wp, r.src_y, r.frac_y);
		end
		return r;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		case (idx)
			REG_XP_GAINS:      sh_xp = v;
			REG_YP_GAINS:      sh_yp = v;
			REG_WP_GAINS:      sh_wp = v;
			REG_XY_OFFSETS:    sh_off = v;
			REG_W_OFFSET:      sh_ow = v[31:0];
			REG_SOURCE_LIMITS: sh_lim = v[31:0];
			REG_BILINEAR_MODE: sh_bil = v[0];
			default: ;
		endcase
	endtask

	// wait for the pipe to drain before touching registers
	task automatic drain();
		while (mapped_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic send_pixel(input logic [11:0] x, input logic [11:0] y,
		input bit known, input out_word_t want);
		out_word_t p;
		p = warp_pixel(x, y);
		if (known && p !== want)
			$error("table row (%0d,%0d): typed %h, model %h", x, y, want, p);
		pix_in.valid <= 1'b1;
		pix_in.data <= '{out_x: x, out_y: y};
		@(posedge clk);
		while (!pix_in.ready) @(posedge clk);
		mapped_q.push_back(p);
	endtask

	task automatic idle_gap();
		pix_in.valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	// receiver stalls in runs of its own
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_out.ready <= 1'b0;
		end else begin
			pix_out.ready <= stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			n_words++;
			if (mapped_q.size() == 0) begin
				$error("unexpected word %h", pix_out.data);
				errors++;
			end else begin
				e = mapped_q.pop_front();
				if (pix_out.data.inside_res == 1'b1) n_inside++;
				if (pix_out.data.inside_res !== e.inside_res) begin
					$error("inside_res: expected %0d got %0d", e.inside_res,
						pix_out.data.inside_res);
					errors++;
				end
				if (pix_out.data.src_x !== e.src_x) begin
					$error("src_x: expected %0d got %0d", e.src_x, pix_out.data.src_x);
					errors++;
				end
				if (pix_out.data.src_y !== e.src_y) begin
					$error("src_y: expected %0d got %0d", e.src_y, pix_out.data.src_y);
					errors++;
				end
				if (pix_out.data.frac_x !== e.frac_x) begin
					$error("frac_x: expected %0d got %0d", e.frac_x, pix_out.data.frac_x);
					errors++;
				end
				if (pix_out.data.frac_y !== e.frac_y) begin
					$error("frac_y: expected %0d got %0d", e.frac_y, pix_out.data.frac_y);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] rnd_coef(input int scale);
		int s;
		s = $urandom_range(0, 2 * scale) - scale;
		return 32'(s);
	endfunction

	initial begin
		pix_row_t tbl[$];
		out_word_t w0;
		int phase, burst, i;
		logic [11:0] x, y;
		logic [31:0] ow;
		arst_n = 1'b0;
		pix_in.valid = 1'b0;
		pix_in.data = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.wdata = '0;
		sh_xp = 64'd1048576;
		sh_yp = 64'd4503599627370496;
		sh_wp = '0;
		sh_off = '0;
		sh_ow = 32'd1048576;
		sh_lim = '0;
		sh_bil = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		w0 = '0;
		// reset matrix is identity with limits 0: only the origin maps inside
		tbl.push_back('{12'd0, 12'd0, 1, '{1'b1, 12'd0, 12'd0, 8'd0, 8'd0}});
		tbl.push_back('{12'd1, 12'd0, 1, w0});
		tbl.push_back('{12'd4095, 12'd4095, 1, w0});
		tbl.push_back('{12'd0, 12'd4095, 1, w0});
		foreach (tbl[k]) send_pixel(tbl[k].x, tbl[k].y, tbl[k].known, tbl[k].want);
		pix_in.valid <= 1'b0;
		drain();

		// wide limits saturate to the coordinate range
		write_reg(REG_SOURCE_LIMITS, 64'hFFFF_FFFF);
		tbl.delete();
		tbl.push_back('{12'd4095, 12'd4095, 1, '{1'b1, 12'd4095, 12'd4095, 8'd0, 8'd0}});
		tbl.push_back('{12'd0, 12'd0, 1, '{1'b1, 12'd0, 12'd0, 8'd0, 8'd0}});
		tbl.push_back('{12'd2048, 12'd17, 0, w0});
		foreach (tbl[k]) send_pixel(tbl[k].x, tbl[k].y, tbl[k].known, tbl[k].want);
		pix_in.valid <= 1'b0;
		drain();

		// zero wp, then negative wp with halving and offsets, both modes
		write_reg(REG_W_OFFSET, 64'd0);
		send_pixel(12'd5, 12'd5, 1, w0);
		send_pixel(12'd4095, 12'd0, 1, w0);
		pix_in.valid <= 1'b0;
		drain();
		write_reg(REG_W_OFFSET, 64'(32'hFFE0_0000));
		write_reg(REG_XY_OFFSETS, {32'hFFF0_0000, 32'hFFF8_0000});
		write_reg(REG_XP_GAINS, {32'd0, 32'hFFF0_0000});
		write_reg(REG_YP_GAINS, {32'hFFF0_0000, 32'd0});
		for (i = 0; i < 6; i++) send_pixel(12'(i * 3), 12'(i * 5), 0, w0);
		send_pixel(12'd4095, 12'd4095, 0, w0);
		pix_in.valid <= 1'b0;
		drain();
		write_reg(REG_BILINEAR_MODE, 64'd1);
		write_reg(REG_WP_GAINS, {32'h8000_0000, 32'h7FFF_FFFF});
		for (i = 0; i < 6; i++) send_pixel(12'(i * 7), 12'(4095 - i), 0, w0);
		pix_in.valid <= 1'b0;
		drain();

		// random phases: mostly sane projective matrices, some extreme ones
		for (phase = 0; phase < 13; phase++) begin
			if (phase % 4 == 3) begin
				write_reg(REG_XP_GAINS, {$urandom, $urandom});
				write_reg(REG_YP_GAINS, {$urandom, $urandom});
				write_reg(REG_WP_GAINS, {$urandom, $urandom});
				write_reg(REG_XY_OFFSETS, {$urandom, $urandom});
				write_reg(REG_W_OFFSET, {32'd0, $urandom});
			end else begin
				write_reg(REG_XP_GAINS, {rnd_coef(300000), 32'h0010_0000 + rnd_coef(400000)});
				write_reg(REG_YP_GAINS, {32'h0010_0000 + rnd_coef(400000), rnd_coef(300000)});
				write_reg(REG_WP_GAINS, {rnd_coef(300), rnd_coef(300)});
				write_reg(REG_XY_OFFSETS, {rnd_coef(200000000), rnd_coef(200000000)});
				ow = (phase % 4 == 1) ? 32'hFFF0_0000 + rnd_coef(200000)
					: 32'h0010_0000 + rnd_coef(200000);
				write_reg(REG_W_OFFSET, {32'd0, ow});
			end
			write_reg(REG_SOURCE_LIMITS, (phase % 5 == 4) ? 64'hFFFF_FFFF
				: {32'd0, 4'd0, 12'($urandom), 4'($urandom_range(0, 1)), 12'($urandom)});
			write_reg(REG_BILINEAR_MODE, 64'(phase % 2));
			stall_en = (phase % 3 != 2);
			i = 0;
			while (i < 48) begin
				burst = $urandom_range(1, 16);
				while (burst > 0 && i < 48) begin
					x = (phase % 4 == 3 || $urandom_range(0, 9) == 0) ? 12'($urandom)
						: 12'($urandom_range(0, 600));
					y = (phase % 4 == 3 || $urandom_range(0, 9) == 0) ? 12'($urandom)
						: 12'($urandom_range(0, 600));
					send_pixel(x, y, 0, w0);
					burst--;
					i++;
				end
				if (stall_en) idle_gap();
			end
			pix_in.valid <= 1'b0;
			drain();
		end

		$display("mapped %0d pixel words over 13 random matrices, %0d landed inside the source",
			n_words, n_inside);
		if (errors == 0) begin
			$display("perspective_warp_coordinate_mapper_test passed");
		end else begin
			$display("perspective_warp_coordinate_mapper_test failed");
		end
		$finish;
	end
endmodule
